>>> design/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the one-wire temperature reader: bus timing,
// command bytes, sequencer phases and the result record.
// ----------------------------------------------------------------------------
package owb_pkg;

	// Bus timing in one-microsecond ticks.
	localparam int RESET_LOW_US = 480;
	localparam int TIMER_W      = 9;

	localparam logic [TIMER_W-1:0] RESET_LOW_LAST = TIMER_W'(RESET_LOW_US - 1);
	localparam logic [TIMER_W-1:0] WAIT_LAST      = TIMER_W'(480 - 1);
	localparam logic [TIMER_W-1:0] PRES_TICK      = TIMER_W'(60);
	localparam logic [TIMER_W-1:0] WSLOT_LAST     = TIMER_W'(60);
	localparam logic [TIMER_W-1:0] RSLOT_LAST     = TIMER_W'(59);
	localparam logic [TIMER_W-1:0] RSAMPLE        = TIMER_W'(15);

	// Command bytes.
	localparam logic [7:0] CMD_CONVERT    = 8'h44;
	localparam logic [7:0] CMD_READ_PAD   = 8'hBE;
	localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
	localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;

	// Fraction scale: one LSB of the low nibble is 0.0625 degree.
	localparam logic [13:0] FRAC_SCALE = 14'd625;

	// Configuration register indexes.
	localparam logic REG_ROM_CODE  = 1'b0;
	localparam logic REG_USE_MATCH = 1'b1;

	// Input item kinds.
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// Sequencer phases, one-hot.
	typedef enum logic [10:0] {
		PH_IDLE = 11'b000_0000_0001,
		PH_R1L  = 11'b000_0000_0010,
		PH_R1W  = 11'b000_0000_0100,
		PH_A1   = 11'b000_0000_1000,
		PH_CV   = 11'b000_0001_0000,
		PH_PL   = 11'b000_0010_0000,
		PH_R2L  = 11'b000_0100_0000,
		PH_R2W  = 11'b000_1000_0000,
		PH_A2   = 11'b001_0000_0000,
		PH_RC   = 11'b010_0000_0000,
		PH_RD   = 11'b100_0000_0000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [13:0] fraction;
		logic [6:0]  whole_degrees;
		logic [7:0]  temp_high_byte;
		logic [7:0]  temp_low_byte;
		logic        presence_seen;
		logic        done_res;
		logic        busy_res;
		logic        drive_low;
	} res_t;

endpackage

>>> design/owb_core.sv
// ----------------------------------------------------------------------------
// owb_core
// Configuration registers and the bus sequencer. One state update per
// accepted item; the result for that item is formed combinationally.
// ----------------------------------------------------------------------------
module owb_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          action,
	input  logic          line_in,
	input  logic          wr_en,
	input  logic          wr_index,
	input  logic [63:0]   wr_data,
	output owb_pkg::res_t res
);
	import owb_pkg::*;

	logic [63:0]        rom_code_q;
	logic               use_match_q;
	phase_t             phase_q, phase_n;
	logic [TIMER_W-1:0] timer_q, timer_n;
	logic [7:0]         shift_q, shift_n;
	logic [2:0]         bit_q, bit_n;
	logic [3:0]         byte_q, byte_n;
	logic [7:0]         low_q, low_n;
	logic [7:0]         high_q, high_n;
	logic               pres_q, pres_n;
	logic [7:0]         wbyte;
	logic               wbit;
	logic               drive_cur;
	logic               done;
	logic [3:0]         byte_inc;
	logic [2:0]         rom_sel;
	logic [7:0]         shift_smp;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_code_q  <= '0;
			use_match_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROM_CODE:  rom_code_q  <= wr_data;
				REG_USE_MATCH: use_match_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Byte being written in the current write slot.
	assign rom_sel = 3'(byte_q - 4'd1);
	always_comb begin
		if (phase_q == PH_CV)       wbyte = CMD_CONVERT;
		else if (phase_q == PH_RC)  wbyte = CMD_READ_PAD;
		else if (!use_match_q)      wbyte = CMD_SKIP_ROM;
		else if (byte_q == 4'd0)    wbyte = CMD_MATCH_ROM;
		else                        wbyte = rom_code_q[{rom_sel, 3'b000} +: 8];
	end
	assign wbit = wbyte[bit_q];

	// Line drive for the current state.
	always_comb begin
		case (phase_q)
			PH_R1L, PH_R2L:               drive_cur = 1'b1;
			PH_A1, PH_CV, PH_A2, PH_RC:   drive_cur = (timer_q == '0) || !wbit;
			PH_PL, PH_RD:                 drive_cur = (timer_q == '0);
			default:                      drive_cur = 1'b0;
		endcase
	end

	assign byte_inc  = byte_q + 4'd1;
	assign shift_smp = (timer_q == RSAMPLE) ? {line_in, shift_q[7:1]} : shift_q;

	// Next state for one item.
	always_comb begin
		phase_n = phase_q;
		timer_n = timer_q;
		shift_n = shift_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		low_n   = low_q;
		high_n  = high_q;
		pres_n  = pres_q;
		done    = 1'b0;
		if (action == ACT_START) begin
			if (phase_q == PH_IDLE) begin
				phase_n = PH_R1L;
				timer_n = '0;
				bit_n   = '0;
				byte_n  = '0;
			end
		end else begin
			case (phase_q)
				PH_R1L, PH_R2L: begin
					if (timer_q >= RESET_LOW_LAST) begin
						phase_n = (phase_q == PH_R1L) ? PH_R1W : PH_R2W;
						timer_n = '0;
					end else begin
						timer_n = timer_q + 1'b1;
					end
				end
				PH_R1W, PH_R2W: begin
					if (timer_q == PRES_TICK) pres_n = line_in;
					if (timer_q >= WAIT_LAST) begin
						phase_n = (phase_q == PH_R1W) ? PH_A1 : PH_A2;
						timer_n = '0;
						bit_n   = '0;
						byte_n  = '0;
					end else begin
						timer_n = timer_q + 1'b1;
					end
				end
				PH_A1, PH_CV, PH_A2, PH_RC: begin
					if (timer_q >= WSLOT_LAST) begin
						timer_n = '0;
						if (bit_q == 3'd7) begin
							bit_n = '0;
							// End of a byte: next address byte, next command, the conversion poll or the read.
							if (phase_q == PH_A1 || phase_q == PH_A2) begin
								if (use_match_q && byte_inc <= 4'd8) begin
									byte_n = byte_inc;
								end else begin
									phase_n = (phase_q == PH_A1) ? PH_CV : PH_RC;
									byte_n  = '0;
								end
							end else if (phase_q == PH_CV) begin
								phase_n = PH_PL;
								byte_n  = '0;
								shift_n = '0;
							end else begin
								phase_n = PH_RD;
								byte_n  = '0;
							end
						end else begin
							bit_n = bit_q + 1'b1;
						end
					end else begin
						timer_n = timer_q + 1'b1;
					end
				end
				PH_PL, PH_RD: begin
					shift_n = shift_smp;
					if (timer_q >= RSLOT_LAST) begin
						timer_n = '0;
						if (phase_q == PH_PL) begin
							// Conversion finished once the device returns a one.
							if (shift_smp[7]) begin
								phase_n = PH_R2L;
								bit_n   = '0;
								byte_n  = '0;
							end
						end else if (bit_q == 3'd7) begin
							bit_n = '0;
							if (byte_q == 4'd0) begin
								low_n  = shift_smp;
								byte_n = 4'd1;
							end else begin
								high_n  = shift_smp;
								phase_n = PH_IDLE;
								byte_n  = '0;
								done    = 1'b1;
							end
						end else begin
							bit_n = bit_q + 1'b1;
						end
					end else begin
						timer_n = timer_q + 1'b1;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			shift_q <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			low_q   <= '0;
			high_q  <= '0;
			pres_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			shift_q <= shift_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			low_q   <= low_n;
			high_q  <= high_n;
			pres_q  <= pres_n;
		end
	end

	// Result for this item. A start from idle shows the first reset level.
	always_comb begin
		res.drive_low      = (action == ACT_START && phase_q == PH_IDLE) ? 1'b1 : drive_cur;
		res.busy_res       = (phase_n != PH_IDLE);
		res.done_res       = done;
		res.presence_seen  = pres_n;
		res.temp_low_byte  = low_n;
		res.temp_high_byte = high_n;
		res.whole_degrees  = {high_n[2:0], low_n[7:4]};
		res.fraction       = 14'(low_n[3:0]) * FRAC_SCALE;
	end

endmodule

>>> design/owb_outreg.sv
// ----------------------------------------------------------------------------
// owb_outreg
// Result register between the sequencer and the output channel. It takes a
// new item whenever it is empty or its current item leaves in this cycle.
// ----------------------------------------------------------------------------
module owb_outreg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  owb_pkg::res_t res_in,
	output logic          room,
	output logic          valid,
	input  logic          ready,
	output owb_pkg::res_t res_out
);
	import owb_pkg::*;

	logic valid_q;
	res_t res_q;

	assign room    = !valid_q || ready;
	assign valid   = valid_q;
	assign res_out = res_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

>>> design/onewire_temperature_reader.sv
// ----------------------------------------------------------------------------
// onewire_temperature_reader
// One-wire bus master that reads the first two scratchpad bytes of a
// temperature sensor.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one item per bus microsecond (tuser low,
// tdata bit 0 the sampled line level) or a start command (tuser high). Every
// input item produces exactly one result item holding the line drive for
// that microsecond, busy and done flags, the presence level and the read
// temperature bytes with their decoded whole degrees and fraction.
// The configuration port sets the 64-bit ROM code (index 0) and the
// match/skip choice (index 1); write it only while no read is running.
// The result is valid in the cycle after input acceptance, and one item is
// accepted per cycle unless the output stalls: the sequencer updates its
// state in the cycle an item is accepted and the result lands in a single
// output register. When the receiver stalls, the held result stays stable
// and s_tready falls, so input items wait; no item is lost or repeated.
// Reset clears the sequencer to idle, the stored bytes and presence to zero,
// the configuration registers to zero and the output register to empty.
// ----------------------------------------------------------------------------
module onewire_temperature_reader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] line_in, [7:1] zero
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                               // [3] presence_seen, [11:4] temp_low_byte,
	                               // [19:12] temp_high_byte, [26:20] whole_degrees,
	                               // [40:27] fraction, [47:41] zero
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [63:0] wr_data
);
	import owb_pkg::*;

	logic accept;
	logic room;
	res_t res_new;
	res_t res_out;

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	owb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.action   (s_tuser),
		.line_in  (s_tdata[0]),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.res      (res_new)
	);

	owb_outreg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.res_in  (res_new),
		.room    (room),
		.valid   (m_tvalid),
		.ready   (m_tready),
		.res_out (res_out)
	);

	// Pack the result, last declared field in the lowest bits.
	assign m_tdata = {7'd0, res_out};

endmodule

>>> design/owb_checker.sv
// ----------------------------------------------------------------------------
// owb_checker
// Port-level checks for the one-wire temperature reader, bound to the top.
// ----------------------------------------------------------------------------
module owb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// An empty output register always takes input.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// The read that completes leaves the master idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[1])
		else $error("done while still busy");

	// Whole degrees follow the stored bytes.
	a_whole: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[26:20] == {m_tdata[14:12], m_tdata[11:8]})
		else $error("whole degrees inconsistent with bytes");

	// Fraction follows the low nibble.
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:27] == 14'(m_tdata[7:4]) * 14'd625)
		else $error("fraction inconsistent with low byte");

endmodule

bind onewire_temperature_reader owb_checker u_owb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
